/* sv/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, status codes and shared types for the triangle circumcircle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int OUT_BITS       = 32;
    localparam int STAT_BITS      = 2;

    // Numerator and denominator widths for coordinates up to 32 bits
    // (differences up to 33 bits, squares 66, products of those 100).
    localparam int NUM_BITS = 104;
    localparam int DEN_BITS = 70;
    localparam int QUO_BITS = NUM_BITS;

    typedef logic [STAT_BITS-1:0] status_t;
    localparam status_t ST_VALID      = 2'd0;
    localparam status_t ST_DEGENERATE = 2'd1;
    localparam status_t ST_OVERFLOW   = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS_DEF-1:0] a_i;
        logic signed [COORD_BITS_DEF-1:0] a_j;
        logic signed [COORD_BITS_DEF-1:0] b_i;
        logic signed [COORD_BITS_DEF-1:0] b_j;
        logic signed [COORD_BITS_DEF-1:0] c_i;
        logic signed [COORD_BITS_DEF-1:0] c_j;
    } triangle_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] center_i;
        logic signed [OUT_BITS-1:0] center_j;
        logic        [OUT_BITS-1:0] radius;
        status_t                    status;
    } circle_t;

endpackage

`default_nettype wire

/* sv/tcc_if.sv */
// ----------------------------------------------------------------------------
// tcc_if
// Valid/ready channel carrying one payload of a generic type.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/tcc_div.sv */
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring floor divider: one quotient bit per stage, shared
// handshake-free shifting stages advanced by an enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div #(
    parameter int NB = 104,
    parameter int DB = 70,
    parameter int TB = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic signed [NB-1:0]   num,
    input  wire logic signed [DB-1:0]   den,
    input  wire logic        [TB-1:0]   tag_in,
    output      logic signed [NB-1:0]   quo,
    output      logic        [TB-1:0]   tag_out
);
    localparam int RB = DB + 1;

    logic [NB-1:0] n_reg   [NB+1];
    logic [RB-1:0] r_reg   [NB+1];
    logic [DB-1:0] d_reg   [NB+1];
    logic          sgn_reg [NB+1];
    logic [TB-1:0] t_reg   [NB+1];

    // stage 0: absolute values
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= num[NB-1] ? NB'(-num) : NB'(num);
            d_reg[0]   <= den[DB-1] ? DB'(-den) : DB'(den);
            r_reg[0]   <= '0;
            sgn_reg[0] <= num[NB-1] ^ den[DB-1];
            t_reg[0]   <= tag_in;
        end
    end

    for (genvar s = 0; s < NB; s++) begin : g_bit
        logic [RB:0] rs;
        logic [RB:0] df;
        always_comb
        begin
            rs = {r_reg[s], n_reg[s][NB-1]};
            df = rs - {2'b00, d_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!df[RB])
                begin
                    r_reg[s+1] <= df[RB-1:0];
                    n_reg[s+1] <= {n_reg[s][NB-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s+1] <= rs[RB-1:0];
                    n_reg[s+1] <= {n_reg[s][NB-2:0], 1'b0};
                end
                d_reg[s+1]   <= d_reg[s];
                sgn_reg[s+1] <= sgn_reg[s];
                t_reg[s+1]   <= t_reg[s];
            end
        end
    end

    logic [NB-1:0] q_reg;
    logic [TB-1:0] tq_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sgn_reg[NB])
                q_reg <= NB'(-n_reg[NB]) - NB'(r_reg[NB] != '0);
            else
                q_reg <= n_reg[NB];
            tq_reg <= t_reg[NB];
        end
    end

    assign quo     = q_reg;
    assign tag_out = tq_reg;

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

`default_nettype wire

/* sv/tcc_sqrt.sv */
// ----------------------------------------------------------------------------
// tcc_sqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_sqrt #(
    parameter int TB = 8
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [63:0]   s_in,
    input  wire logic [TB-1:0] tag_in,
    output      logic [31:0]   root,
    output      logic [TB-1:0] tag_out
);
    logic [63:0] s_reg [33];
    logic [31:0] q_reg [33];
    logic [TB-1:0] t_reg [33];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= s_in;
            q_reg[0] <= '0;
            t_reg[0] <= tag_in;
        end
    end

    for (genvar k = 0; k < 32; k++) begin : g_step
        localparam int SH = 2 * (31 - k);
        logic [65:0] trial;
        always_comb
            trial = ({34'd0, q_reg[k]} << (SH + 2)) | (66'd1 << SH);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({2'b00, s_reg[k]} >= trial)
                begin
                    s_reg[k+1] <= s_reg[k] - trial[63:0];
                    q_reg[k+1] <= {q_reg[k][30:0], 1'b1};
                end
                else
                begin
                    s_reg[k+1] <= s_reg[k];
                    q_reg[k+1] <= {q_reg[k][30:0], 1'b0};
                end
                t_reg[k+1] <= t_reg[k];
            end
        end
    end

    assign root    = q_reg[32];
    assign tag_out = t_reg[32];
endmodule

`default_nettype wire

/* sv/triangle_circumcircle_unit.sv */
// Throughput: one triangle per cycle while the output is not stalled; the
// whole pipeline advances together.
// The long divider (one quotient bit per stage) and the 32-stage square root
// set the latency. A stalled output freezes every stage.
// Reset clears the valid bits only; no state survives between requests.
// ----------------------------------------------------------------------------
// triangle_circumcircle_unit
// Circumcenter by exact floor division and radius by integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcircle_unit #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    tcc_if.sink   in_ch,
    tcc_if.source out_ch
);
    import tcc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int XB = CB + 1;
    localparam int LAT = NUM_BITS + 2 + 33 + 10;
    localparam int TB = 1;

    // FRAC_BITS only places the binary point; the arithmetic ignores it.
    localparam int FB_UNUSED = FRAC_BITS;

    logic en;
    logic [LAT-1:0] v_reg;
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-2:0], in_ch.valid};
    end

    // stage 1: differences
    logic signed [CB-1:0] ai, aj, bi, bj, ci, cj;
    assign ai = CB'(in_ch.data.a_i);
    assign aj = CB'(in_ch.data.a_j);
    assign bi = CB'(in_ch.data.b_i);
    assign bj = CB'(in_ch.data.b_j);
    assign ci = CB'(in_ch.data.c_i);
    assign cj = CB'(in_ch.data.c_j);

    logic signed [XB-1:0] bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [CB-1:0] ai1_reg, aj1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bx1_reg <= XB'(bi) - XB'(ai);
            by1_reg <= XB'(bj) - XB'(aj);
            cx1_reg <= XB'(ci) - XB'(ai);
            cy1_reg <= XB'(cj) - XB'(aj);
            ai1_reg <= ai;
            aj1_reg <= aj;
        end
    end

    // stage 2: products of differences
    localparam int PB = 2 * XB;
    logic signed [PB-1:0] bxx_reg, byy_reg, cxx_reg, cyy_reg, bxcy_reg, bycx_reg;
    logic signed [XB-1:0] bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [CB-1:0] ai2_reg, aj2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bxx_reg  <= bx1_reg * bx1_reg;
            byy_reg  <= by1_reg * by1_reg;
            cxx_reg  <= cx1_reg * cx1_reg;
            cyy_reg  <= cy1_reg * cy1_reg;
            bxcy_reg <= bx1_reg * cy1_reg;
            bycx_reg <= by1_reg * cx1_reg;
            bx2_reg <= bx1_reg; by2_reg <= by1_reg;
            cx2_reg <= cx1_reg; cy2_reg <= cy1_reg;
            ai2_reg <= ai1_reg; aj2_reg <= aj1_reg;
        end
    end

    // stage 3: sums
    logic signed [DEN_BITS-1:0] bb3_reg, cc3_reg, d3_reg;
    logic signed [XB-1:0] bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic signed [CB-1:0] ai3_reg, aj3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb3_reg <= DEN_BITS'(bxx_reg) + DEN_BITS'(byy_reg);
            cc3_reg <= DEN_BITS'(cxx_reg) + DEN_BITS'(cyy_reg);
            d3_reg  <= (DEN_BITS'(bxcy_reg) - DEN_BITS'(bycx_reg)) <<< 1;
            bx3_reg <= bx2_reg; by3_reg <= by2_reg;
            cx3_reg <= cx2_reg; cy3_reg <= cy2_reg;
            ai3_reg <= ai2_reg; aj3_reg <= aj2_reg;
        end
    end

    // stage 4a: partial numerator products; the squared lengths are never
    // negative, so split them into unsigned halves to keep multipliers small
    localparam int HB = DEN_BITS / 2;
    localparam int HI = DEN_BITS - HB;
    localparam int MB = XB + HI + 1;
    logic signed [HB:0] bbl, ccl;
    logic signed [HI:0] bbh, cch;
    assign bbl = $signed({1'b0, bb3_reg[HB-1:0]});
    assign ccl = $signed({1'b0, cc3_reg[HB-1:0]});
    assign bbh = $signed({1'b0, bb3_reg[DEN_BITS-1:HB]});
    assign cch = $signed({1'b0, cc3_reg[DEN_BITS-1:HB]});

    logic signed [MB-1:0] p1l_reg, p1h_reg, p2l_reg, p2h_reg;
    logic signed [MB-1:0] p3l_reg, p3h_reg, p4l_reg, p4h_reg;
    logic signed [DEN_BITS-1:0] d4a_reg;
    logic signed [CB-1:0] ai4a_reg, aj4a_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1l_reg <= cy3_reg * bbl;
            p1h_reg <= cy3_reg * bbh;
            p2l_reg <= by3_reg * ccl;
            p2h_reg <= by3_reg * cch;
            p3l_reg <= bx3_reg * ccl;
            p3h_reg <= bx3_reg * cch;
            p4l_reg <= cx3_reg * bbl;
            p4h_reg <= cx3_reg * bbh;
            d4a_reg <= d3_reg;
            ai4a_reg <= ai3_reg; aj4a_reg <= aj3_reg;
        end
    end

    // stage 4b: recombine the halves into full numerator products
    logic signed [NUM_BITS-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [DEN_BITS-1:0] d4_reg;
    logic signed [CB-1:0] ai4_reg, aj4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= (NUM_BITS'(p1h_reg) <<< HB) + NUM_BITS'(p1l_reg);
            p2_reg <= (NUM_BITS'(p2h_reg) <<< HB) + NUM_BITS'(p2l_reg);
            p3_reg <= (NUM_BITS'(p3h_reg) <<< HB) + NUM_BITS'(p3l_reg);
            p4_reg <= (NUM_BITS'(p4h_reg) <<< HB) + NUM_BITS'(p4l_reg);
            d4_reg <= d4a_reg;
            ai4_reg <= ai4a_reg; aj4_reg <= aj4a_reg;
        end
    end

    // stage 5: numerators; a zero divisor is replaced by one and flagged
    logic signed [NUM_BITS-1:0] nx5_reg, ny5_reg;
    logic signed [DEN_BITS-1:0] d5_reg;
    logic deg5_reg;
    logic signed [CB-1:0] ai5_reg, aj5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg  <= p1_reg - p2_reg;
            ny5_reg  <= p3_reg - p4_reg;
            deg5_reg <= (d4_reg == '0);
            d5_reg   <= (d4_reg == '0) ? DEN_BITS'(1) : d4_reg;
            ai5_reg  <= ai4_reg; aj5_reg <= aj4_reg;
        end
    end

    localparam int DTB = 1 + 2 * CB;
    logic [DTB-1:0] tag5, tagq;
    logic signed [NUM_BITS-1:0] ux, uy;
    logic [TB-1:0] unused_t;
    assign tag5 = {deg5_reg, ai5_reg, aj5_reg};

    tcc_div #(.NB(NUM_BITS), .DB(DEN_BITS), .TB(DTB)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en), .num(nx5_reg), .den(d5_reg),
        .tag_in(tag5), .quo(ux), .tag_out(tagq)
    );
    tcc_div #(.NB(NUM_BITS), .DB(DEN_BITS), .TB(TB)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en), .num(ny5_reg), .den(d5_reg),
        .tag_in(1'b0), .quo(uy), .tag_out(unused_t)
    );

    // post stage A: center, magnitudes
    logic deg_a_reg;
    logic signed [NUM_BITS-1:0] cxa_reg, cya_reg;
    logic [NUM_BITS-1:0] mx_a_reg, my_a_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_a_reg <= tagq[DTB-1];
            cxa_reg <= NUM_BITS'(ux) + NUM_BITS'($signed(tagq[2*CB-1:CB]));
            cya_reg <= NUM_BITS'(uy) + NUM_BITS'($signed(tagq[CB-1:0]));
            mx_a_reg <= ux[NUM_BITS-1] ? NUM_BITS'(-ux) : NUM_BITS'(ux);
            my_a_reg <= uy[NUM_BITS-1] ? NUM_BITS'(-uy) : NUM_BITS'(uy);
        end
    end

    // post stage B: saturate center, squares of magnitudes
    localparam logic signed [NUM_BITS-1:0] SMAX = NUM_BITS'(64'sh7FFFFFFF);
    localparam logic signed [NUM_BITS-1:0] SMIN = -NUM_BITS'(64'sh80000000);
    logic deg_b_reg, covf_b_reg, big_b_reg;
    logic [OUT_BITS-1:0] cx_b_reg, cy_b_reg;
    logic [63:0] sx_b_reg, sy_b_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_b_reg <= deg_a_reg;
            cx_b_reg <= (cxa_reg > SMAX) ? 32'h7FFFFFFF :
                        (cxa_reg < SMIN) ? 32'h80000000 : cxa_reg[31:0];
            cy_b_reg <= (cya_reg > SMAX) ? 32'h7FFFFFFF :
                        (cya_reg < SMIN) ? 32'h80000000 : cya_reg[31:0];
            covf_b_reg <= (cxa_reg > SMAX) || (cxa_reg < SMIN)
                       || (cya_reg > SMAX) || (cya_reg < SMIN);
            big_b_reg <= (mx_a_reg[NUM_BITS-1:32] != '0)
                      || (my_a_reg[NUM_BITS-1:32] != '0);
            sx_b_reg <= mx_a_reg[31:0] * mx_a_reg[31:0];
            sy_b_reg <= my_a_reg[31:0] * my_a_reg[31:0];
        end
    end

    // post stage C: squared radius
    logic deg_c_reg, covf_c_reg, rovf_c_reg;
    logic [OUT_BITS-1:0] cx_c_reg, cy_c_reg;
    logic [63:0] r2_c_reg;
    logic [64:0] r2sum;
    assign r2sum = {1'b0, sx_b_reg} + {1'b0, sy_b_reg};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_c_reg <= deg_b_reg;
            covf_c_reg <= covf_b_reg;
            rovf_c_reg <= big_b_reg || r2sum[64];
            cx_c_reg <= cx_b_reg; cy_c_reg <= cy_b_reg;
            r2_c_reg <= r2sum[63:0];
        end
    end

    localparam int STB = 3 + 2 * OUT_BITS;
    logic [STB-1:0] stag;
    logic [STB-1:0] stag_o;
    logic [31:0] root;
    assign stag = {deg_c_reg, covf_c_reg, rovf_c_reg, cx_c_reg, cy_c_reg};

    tcc_sqrt #(.TB(STB)) u_sqrt (
        .clk(clk), .en(en), .s_in(r2_c_reg), .tag_in(stag),
        .root(root), .tag_out(stag_o)
    );

    // output register
    logic deg_o, covf_o, rovf_o;
    assign {deg_o, covf_o, rovf_o} = stag_o[STB-1:STB-3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (deg_o)
            begin
                out_ch.data.center_i <= '0;
                out_ch.data.center_j <= '0;
                out_ch.data.radius   <= '0;
                out_ch.data.status   <= ST_DEGENERATE;
            end
            else
            begin
                out_ch.data.center_i <= stag_o[2*OUT_BITS-1:OUT_BITS];
                out_ch.data.center_j <= stag_o[OUT_BITS-1:0];
                out_ch.data.radius   <= rovf_o ? 32'hFFFFFFFF : root;
                out_ch.data.status   <= (covf_o || rovf_o) ? ST_OVERFLOW : ST_VALID;
            end
        end
    end
    assign out_ch.valid = v_reg[LAT-1];

    logic unused_fb;
    assign unused_fb = (FB_UNUSED < 0) ^ unused_t[0];

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("input ready not tied to pipeline advance");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.status == ST_DEGENERATE |->
        out_ch.data.radius == '0)
        else $error("degenerate result with radius");
endmodule

`default_nettype wire

/* dv/triangle_circumcircle_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_circumcircle_unit_test
// Streams triangles through the circumcircle unit. Checks each result,
// field by field, against an exact integer circumcenter and radius
// computed here. Covers degenerate, overflow and ordinary cases under
// varied idle patterns and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcircle_unit_test;

    import tcc_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam int PERIOD_NS = 10;

    logic clk;
    logic rst_n;

    tcc_if #(.payload_t(triangle_t)) tri_ch ();
    tcc_if #(.payload_t(circle_t))   circ_ch ();

    triangle_circumcircle_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (tri_ch),
        .out_ch (circ_ch)
    );

    circle_t expected_circles[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD_NS / 2) clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic wide_t floor_div(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic logic signed [31:0] clamp32(wide_t v, ref logic ovf);
        if (v > wide_t'(32'sh7FFF_FFFF))
        begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -wide_t'(64'sh8000_0000))
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] floor_sqrt(logic [63:0] s);
        logic [31:0]  root;
        logic [31:0]  trial;
        logic [127:0] sq;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            sq    = 128'(trial) * 128'(trial);
            if (sq <= 128'(s))
                root = trial;
        end
        return root;
    endfunction

    function automatic circle_t predict_circle(triangle_t t);
        wide_t   ax, ay, bx, by, cx, cy, bb, cc, det, ux, uy, mx, my, r2;
        logic    ovf;
        circle_t res;
        ovf = 1'b0;
        ax  = t.a_i;
        ay  = t.a_j;
        bx  = wide_t'(t.b_i) - ax;
        by  = wide_t'(t.b_j) - ay;
        cx  = wide_t'(t.c_i) - ax;
        cy  = wide_t'(t.c_j) - ay;
        bb  = bx * bx + by * by;
        cc  = cx * cx + cy * cy;
        det = 2 * (bx * cy - by * cx);
        if (det == 0)
        begin
            res = '{center_i: '0, center_j: '0, radius: '0, status: ST_DEGENERATE};
            return res;
        end
        ux = floor_div(cy * bb - by * cc, det);
        uy = floor_div(bx * cc - cx * bb, det);
        res.center_i = clamp32(ax + ux, ovf);
        res.center_j = clamp32(ay + uy, ovf);
        // radius is measured to the unclamped center
        mx = (ux < 0) ? -ux : ux;
        my = (uy < 0) ? -uy : uy;
        r2 = mx * mx + my * my;
        if (mx > 128'hFFFF_FFFF || my > 128'hFFFF_FFFF || r2 >= (wide_t'(1) <<< 64))
        begin
            res.radius = 32'hFFFF_FFFF;
            ovf = 1'b1;
        end
        else
            res.radius = floor_sqrt(r2[63:0]);
        res.status = ovf ? ST_OVERFLOW : ST_VALID;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_cycles > 0)
        begin
            circ_ch.ready <= 1'b0;
            stall_cycles  <= stall_cycles - 1;
        end
        else
            circ_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        circle_t want;
        circle_t got;
        if (rst_n && circ_ch.valid && circ_ch.ready)
        begin
            got = circ_ch.data;
            if (expected_circles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_circles.pop_front();
                if (got.center_i !== want.center_i || got.center_j !== want.center_j
                    || got.radius !== want.radius || got.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_triangle(triangle_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tri_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.data  <= t;
        @(posedge clk);
        while (!tri_ch.ready)
            @(posedge clk);
        expected_circles.push_back(predict_circle(t));
    endtask

    function automatic triangle_t random_triangle();
        triangle_t t;
        int        kind;
        int        ox, oy, dx, dy, m, n;
        kind = $urandom_range(9);
        ox   = $urandom;
        oy   = $urandom;
        t.a_i = 24'($urandom);
        t.a_j = 24'($urandom);
        t.b_i = 24'($urandom);
        t.b_j = 24'($urandom);
        t.c_i = 24'($urandom);
        t.c_j = 24'($urandom);
        if (kind < 4)
            return t;
        if (kind < 7)
        begin
            // small triangle near a random origin
            t.a_i = 24'(ox);
            t.a_j = 24'(oy);
            t.b_i = 24'(ox + int'($urandom_range(128)) - 64);
            t.b_j = 24'(oy + int'($urandom_range(128)) - 64);
            t.c_i = 24'(ox + int'($urandom_range(128)) - 64);
            t.c_j = 24'(oy + int'($urandom_range(128)) - 64);
            return t;
        end
        // along a line, exactly or with a slight offset
        dx = int'($urandom_range(2048)) - 1024;
        dy = int'($urandom_range(2048)) - 1024;
        m  = int'($urandom_range(4096)) - 2048;
        n  = int'($urandom_range(4096)) - 2048;
        t.a_i = 24'(ox);
        t.a_j = 24'(oy);
        t.b_i = 24'(ox + dx * m);
        t.b_j = 24'(oy + dy * m);
        t.c_i = 24'(ox + dx * n + ((kind == 9) ? 0 : int'($urandom_range(2)) - 1));
        t.c_j = 24'(oy + dy * n + ((kind == 9) ? 0 : int'($urandom_range(2)) - 1));
        return t;
    endfunction

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
            send_triangle(random_triangle());
    endtask

    task automatic wait_drained();
        while (expected_circles.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        localparam logic signed [23:0] MN = 24'sh80_0000;
        localparam logic signed [23:0] MX = 24'sh7F_FFFF;
        triangle_t list[$];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        list = '{
            '{0, 0, 0, 0, 0, 0},
            '{5, 5, 5, 5, 9, 1},
            '{1, 1, 9, 2, 1, 1},
            '{0, 0, 3, 3, 6, 6},
            '{0, 0, 256, 0, 0, 256},
            '{0, 0, 1, 0, 0, 1},
            '{-3, -7, 4, -2, -1, 5},
            '{MN, MN, MX, MN, MN, MX},
            '{MX, MX, MN, MX, MX, MN},
            '{MN, MN, MX, MX, MN, MX},
            '{MN, MN, MX, MX, 0, 1},
            '{MN, 0, MX, 1, 0, 0},
            '{MN, MN, MX, MX, 1, 0},
            '{MX, MN, MN, MX, 0, 1},
            '{MN, MX, 0, 0, MX, MN},
            '{-1, -1, -1, 0, 0, -1},
            '{MX, MX, MX, MX - 1, MX - 1, MX},
            '{MN, MN, MN, MN + 1, MN + 1, MN},
            '{100, -100, -100, 100, 100, 100}
        };
        foreach (list[k])
            send_triangle(list[k]);
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 33;
        recv_idle_pct = 70;
        run_random(270);
    endtask

    task automatic test_receiver_idle();
        send_idle_pct = 70;
        recv_idle_pct = 33;
        run_random(270);
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(250);
    endtask

    task automatic test_full_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_cycles  = 600;
        run_random(240);
    endtask

    initial
    begin
        mismatches    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_cycles  = 0;
        rst_n         = 1'b0;
        tri_ch.valid  = 1'b0;
        tri_ch.data   = '0;
        circ_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_sender_idle();
        test_receiver_idle();
        test_no_idle();
        test_full_stall();

        tri_ch.valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge clk);

        if (mismatches == 0 && expected_circles.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/tcc_pkg.sv
sv/tcc_if.sv
sv/tcc_div.sv
sv/tcc_sqrt.sv
sv/triangle_circumcircle_unit.sv
dv/triangle_circumcircle_unit_test.sv
